@@ sv/fm_total_level_volume_shadow_defines.svh @@
// ----------------------------------------------------------------------------
// fm total level volume shadow assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef FM_TOTAL_LEVEL_VOLUME_SHADOW_DEFINES_SVH
`define FM_TOTAL_LEVEL_VOLUME_SHADOW_DEFINES_SVH

// same-cycle implication
`define FMTL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fmtl check failed");

// next-cycle implication
`define FMTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fmtl check failed");

`endif

@@ sv/fmtl_pkg.sv @@
// ----------------------------------------------------------------------------
// fmtl_pkg
// shared widths, op codes, sequencer struct and carrier mask table
// ----------------------------------------------------------------------------
package fmtl_pkg;

   localparam int OP_W    = 2;
   localparam int ADDR_W  = 9;
   localparam int DATA_W  = 8;
   localparam int CH_W    = 3;
   localparam int VOL_W   = 8;
   localparam int LEVEL_W = 7;
   localparam int ALG_W   = 3;
   localparam int SLOT_W  = 2;

   // op codes
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OP_W-1:0] OP_VOLUME = 2'd1;
   localparam logic [OP_W-1:0] OP_MUTE   = 2'd2;

   localparam logic [LEVEL_W-1:0]      LEVEL_RESET = 7'h7F;
   localparam logic signed [VOL_W-1:0] MUTE_VOL    = -8'sd127;

   // sequencer view handed to the top level
   typedef struct packed {
      logic                    busy;
      logic                    emit;
      logic                    last;
      logic [CH_W-1:0]         ch;
      logic [SLOT_W-1:0]       slot;
      logic signed [VOL_W-1:0] vol;
   } fmtl_seq_type;

   // carrier operators per algorithm, bit n is operator slot n
   function automatic logic [3:0] carrier_mask(input logic [ALG_W-1:0] alg);
      logic [3:0] m;
      case (alg)
         3'd4:    m = 4'hC;
         3'd5:    m = 4'hE;
         3'd6:    m = 4'hE;
         3'd7:    m = 4'hF;
         default: m = 4'h8;
      endcase
      return m;
   endfunction

endpackage

@@ sv/fm_total_level_volume_shadow.sv @@
// ----------------------------------------------------------------------------
// fm_total_level_volume_shadow
// register bus front end with total level shadowing and volume rewrites
// ----------------------------------------------------------------------------
// Input words arrive on the req_ channel (valid/ready), output writes leave
// on the rsp_ channel (valid/ready) through a single output register.
// A register write word is forwarded as one output word, loaded into the
// output register on the accepting edge, and updates the level or algorithm
// shadow when its address hits those ranges.
// A set-volume word walks the operator slots of the channel up to its last
// carrier slot, one slot per cycle while no carrier slot waits, through the
// shared level unit, a carrier slot giving one output word. A mute word walks
// channels 0,4,1,5,2,6. The sequencer steps the slots; a carrier slot waits
// while the output register is full and the receiver stalls, then resumes.
// req_ready is high while no slot walk runs and the output register is free
// or being taken. The last output word of every input word has rsp_last set.
// Reset clears the handshake state and loads levels with 0x7F and
// algorithms with 0; an unused op code is taken and gives no output.
// ----------------------------------------------------------------------------
`include "fm_total_level_volume_shadow_defines.svh"

module fm_total_level_volume_shadow import fmtl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [OP_W-1:0]         req_op,
   input  logic [ADDR_W-1:0]       req_addr,
   input  logic [DATA_W-1:0]       req_data,
   input  logic [CH_W-1:0]         req_channel,
   input  logic signed [VOL_W-1:0] req_volume,
   input  logic                    req_mute,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_psg_port,
   output logic [ADDR_W-1:0]       rsp_out_addr,
   output logic [DATA_W-1:0]       rsp_out_data,
   output logic                    rsp_last
);

   fmtl_seq_type seq;

   logic                    accept;
   logic                    out_free;
   logic                    wr_word;
   logic                    seq_start;
   logic signed [VOL_W-1:0] start_vol;
   logic [LEVEL_W-1:0]      level;
   logic [ALG_W-1:0]        alg;
   logic [DATA_W-1:0]       new_level;
   logic                    emit_take;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              psg_ff,       psg_in;
   logic [ADDR_W-1:0] addr_ff,      addr_in;
   logic [DATA_W-1:0] data_ff,      data_in;
   logic              last_ff,      last_in;

   // input handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !seq.busy && out_free;
   assign accept    = req_valid && req_ready;
   assign wr_word   = accept && (req_op == OP_WRITE);
   assign seq_start = accept && ((req_op == OP_VOLUME) || (req_op == OP_MUTE));
   assign start_vol = (req_op == OP_VOLUME) ? req_volume :
                      (req_mute ? MUTE_VOL : '0);

   fmtl_shadow u_shadow (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_word),
      .wr_addr  (req_addr),
      .wr_data  (req_data),
      .rd_ch    (seq.ch),
      .rd_slot  (seq.slot),
      .rd_level (level),
      .rd_alg   (alg)
   );

   fmtl_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (seq_start),
      .start_multi (req_op == OP_MUTE),
      .start_ch    ((req_op == OP_VOLUME) ? req_channel : '0),
      .start_vol   (start_vol),
      .mask        (carrier_mask(alg)),
      .advance     (out_free),
      .seq         (seq)
   );

   fmtl_alu u_alu (
      .level  (level),
      .vol    (seq.vol),
      .result (new_level)
   );

   // output register load
   assign emit_take = seq.emit && out_free;

   always_comb begin
      psg_in  = psg_ff;
      addr_in = addr_ff;
      data_in = data_ff;
      last_in = last_ff;
      if (wr_word) begin
         psg_in  = (req_addr[ADDR_W-1:4] == '0);
         addr_in = req_addr;
         data_in = req_data;
         last_in = 1'b1;
      end else if (emit_take) begin
         psg_in  = 1'b0;
         addr_in = {seq.ch[2], 4'h4, seq.slot, seq.ch[1:0]};
         data_in = new_level;
         last_in = seq.last;
      end
      if (wr_word || emit_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      psg_ff  <= psg_in;
      addr_ff <= addr_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_psg_port = psg_ff;
   assign rsp_out_addr = addr_ff;
   assign rsp_out_data = data_ff;
   assign rsp_last     = last_ff;

   // checks
   `FMTL_ASSERT_NEXT(a_walk_blocks_input, clock, reset, seq_start, !req_ready)
   `FMTL_ASSERT_NOW(a_psg_word_is_last, clock, reset, rsp_valid && rsp_psg_port, rsp_last)
   `FMTL_ASSERT_NOW(a_inner_word_is_level, clock, reset, rsp_valid && !rsp_last,
      (rsp_out_addr[7:4] == 4'h4) && !rsp_psg_port && (rsp_out_data[7] == 1'b0))

endmodule

@@ sv/fmtl_shadow.sv @@
// ----------------------------------------------------------------------------
// fmtl_shadow
// total level and algorithm shadow registers with one write port
// ----------------------------------------------------------------------------
module fmtl_shadow import fmtl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [DATA_W-1:0]  wr_data,
   input  logic [CH_W-1:0]    rd_ch,
   input  logic [SLOT_W-1:0]  rd_slot,
   output logic [LEVEL_W-1:0] rd_level,
   output logic [ALG_W-1:0]   rd_alg
);

   logic [LEVEL_W-1:0] level_ff [32];
   logic [ALG_W-1:0]   alg_ff   [8];

   logic       level_hit;
   logic       alg_hit;
   logic [4:0] level_wr_idx;
   logic [2:0] alg_wr_idx;

   // address decode, bank from bit 8
   assign level_hit    = wr_en && (wr_addr[7:4] == 4'h4);
   assign alg_hit      = wr_en && (wr_addr[7:2] == 6'b101100);
   assign level_wr_idx = {wr_addr[8], wr_addr[3:0]};
   assign alg_wr_idx   = {wr_addr[8], wr_addr[1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) level_ff[i] <= LEVEL_RESET;
         for (int i = 0; i < 8; i++) alg_ff[i] <= '0;
      end else begin
         if (level_hit) level_ff[level_wr_idx] <= wr_data[LEVEL_W-1:0];
         if (alg_hit) alg_ff[alg_wr_idx] <= wr_data[ALG_W-1:0];
      end
   end

   // operator slot = channel low bits + 4 * slot, bank from channel bit 2
   assign rd_level = level_ff[{rd_ch[2], rd_slot, rd_ch[1:0]}];
   assign rd_alg   = alg_ff[rd_ch];

endmodule

@@ sv/fmtl_alu.sv @@
// ----------------------------------------------------------------------------
// fmtl_alu
// shared level unit: shadowed level minus volume, saturated to 0..127
// ----------------------------------------------------------------------------
module fmtl_alu import fmtl_pkg::*; (
   input  logic [LEVEL_W-1:0]       level,
   input  logic signed [VOL_W-1:0]  vol,
   output logic [DATA_W-1:0]        result
);

   logic signed [VOL_W+1:0] diff;

   // range -127..255 fits in ten signed bits
   assign diff = $signed({3'b000, level}) - $signed({{2{vol[VOL_W-1]}}, vol});

   always_comb begin
      if (diff < 0) begin
         result = '0;
      end else if (diff > 10'sd127) begin
         result = 8'h7F;
      end else begin
         result = {1'b0, diff[LEVEL_W-1:0]};
      end
   end

endmodule

@@ sv/fmtl_seq.sv @@
// ----------------------------------------------------------------------------
// fmtl_seq
// sequencer walking operator slots of one channel or the mute channel list
// ----------------------------------------------------------------------------
module fmtl_seq import fmtl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    start_multi,
   input  logic [CH_W-1:0]         start_ch,
   input  logic signed [VOL_W-1:0] start_vol,
   input  logic [3:0]              mask,
   input  logic                    advance,
   output fmtl_seq_type            seq
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                    state_ff,  state_in;
   logic                    multi_ff,  multi_in;
   logic [2:0]              chidx_ff,  chidx_in;
   logic [CH_W-1:0]         ch_ff,     ch_in;
   logic [SLOT_W-1:0]       slot_ff,   slot_in;
   logic signed [VOL_W-1:0] vol_ff,    vol_in;

   logic       carrier;
   logic       end_ch;
   logic       final_ch;
   logic       step;
   logic [3:0] rest;
   logic [2:0] chidx_nx;

   // no carriers above this slot ends the channel
   assign rest     = mask >> ({2'b00, slot_ff} + 4'd1);
   assign carrier  = mask[slot_ff];
   assign end_ch   = (slot_ff == 2'd3) || (rest == 4'h0);
   assign final_ch = !multi_ff || (chidx_ff == 3'd5);
   assign step     = (state_ff == ST_RUN) && (!carrier || advance);
   assign chidx_nx = chidx_ff + 3'd1;

   always_comb begin
      state_in = state_ff;
      multi_in = multi_ff;
      chidx_in = chidx_ff;
      ch_in    = ch_ff;
      slot_in  = slot_ff;
      vol_in   = vol_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               multi_in = start_multi;
               chidx_in = '0;
               ch_in    = start_ch;
               slot_in  = '0;
               vol_in   = start_vol;
            end
         end
         ST_RUN: begin
            if (step) begin
               if (!end_ch) begin
                  slot_in = slot_ff + 2'd1;
               end else if (final_ch) begin
                  state_in = ST_IDLE;
               end else begin
                  // mute order 0,4,1,5,2,6
                  chidx_in = chidx_nx;
                  ch_in    = {chidx_nx[0], chidx_nx[2:1]};
                  slot_in  = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      multi_ff <= multi_in;
      chidx_ff <= chidx_in;
      ch_ff    <= ch_in;
      slot_ff  <= slot_in;
      vol_ff   <= vol_in;
   end

   assign seq.busy = (state_ff == ST_RUN);
   assign seq.emit = (state_ff == ST_RUN) && carrier;
   assign seq.last = end_ch && final_ch;
   assign seq.ch   = ch_ff;
   assign seq.slot = slot_ff;
   assign seq.vol  = vol_ff;

endmodule
